### hw/rtl/scr_pkg.sv
// shared types and constants for the sync-framed checksum receiver
// no dependencies
`timescale 1ns / 1ps

package scr_pkg;

    // sync value that opens every frame
    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_ERR  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // load request into the result register
    typedef struct packed {
        logic       load;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       frame_bad;
    } out_req_t;

endpackage

### hw/rtl/scr_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/scr_out.sv
// result register for the receiver: holds one word until the sink takes it
// depends on scr_pkg
`timescale 1ns / 1ps

module scr_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  scr_pkg::out_req_t req,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [7:0]        m_data_byte,
    output logic [5:0]        m_byte_index,
    output logic              m_last,
    output logic              m_frame_bad,
    output logic              free
);

    import scr_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic [5:0] index_reg;
    logic       last_reg;
    logic       bad_reg;

    // slot is free next edge when empty or being taken now
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.load) begin
            data_reg  <= req.data_byte;
            index_reg <= req.byte_index;
            last_reg  <= req.last;
            bad_reg   <= req.frame_bad;
        end
    end

    assign m_valid      = valid_reg;
    assign m_data_byte  = data_reg;
    assign m_byte_index = index_reg;
    assign m_last       = last_reg;
    assign m_frame_bad  = bad_reg;

endmodule

### hw/rtl/sync_checksum_frame_receiver_core.sv
// sync-byte framed receiver with additive checksum: sequencer around one frame ram
// depends on scr_pkg, scr_ram, scr_out
`timescale 1ns / 1ps

//  channel | direction | ports                                               | handshake
//  --------+-----------+-----------------------------------------------------+------------------
//  input   | in        | s_rx_byte                                           | s_valid / s_ready
//  result  | out       | m_data_byte, m_byte_index, m_last, m_frame_bad      | m_valid / m_ready
//
//  a byte that does not complete a frame is stored with one ram write; an empty buffer keeps only the sync byte
//  the completing byte starts a checksum walk: FRAME_BYTES-2 ram reads
//  a good frame then streams out one ram read at a time, each word through the result register
//  a bad frame gives one error word, then a scan/copy walk over entries 1 to FRAME_BYTES-1
//  aresetn is synchronous; the ram needs no clearing pass, only the fill count, state and flags are cleared
//  s_ready is low outside idle (walks, emission, error word); a stalled sink holds the emission and the error word

module sync_checksum_frame_receiver_core #(
    parameter int FRAME_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [5:0] m_byte_index,
    output logic       m_last,
    output logic       m_frame_bad
);

    import scr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int FW = $clog2(FRAME_BYTES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    // sequencer state
    state_t        state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;       // stored bytes in the buffer
    logic [AW-1:0] cnt_reg, cnt_next;         // next ram address to read
    logic          iss_done_reg, iss_done_next;
    logic          rd_vld_reg, rd_vld_next;   // read data valid for sum/scan
    logic          rd_last_reg, rd_last_next;
    logic          emit_pend_reg, emit_pend_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next; // address of the data now on rd_data
    logic [7:0]    acc_reg, acc_next;         // running checksum
    logic [7:0]    byte1_reg, byte1_next;     // copy of buffer entry 1
    logic          found_reg, found_next;     // resync found a sync byte
    logic [AW-1:0] off_reg, off_next;         // position of that sync byte

    // ram port
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [7:0]    mem_rd_data;

    out_req_t      out_req;
    logic          out_free;
    logic          s_acc;
    logic [7:0]    sum_now;
    logic [AW-1:0] copy_dst;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign sum_now  = acc_reg + mem_rd_data;
    assign copy_dst = rd_addr_reg - off_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        iss_done_next  = iss_done_reg;
        acc_next       = acc_reg;
        byte1_next     = byte1_reg;
        found_next     = found_reg;
        off_next       = off_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = fill_reg[AW-1:0];
        mem_wr_data    = s_rx_byte;
        mem_rd_en      = 1'b0;
        emit_pend_next = 1'b0;
        rd_last_next   = (cnt_reg == LAST_ADDR);

        // an issued emit read passes the ram read register, then loads the result register
        out_req            = '0;
        if (emit_pend_reg) begin
            out_req.load       = 1'b1;
            out_req.data_byte  = mem_rd_data;
            out_req.byte_index = 6'(rd_addr_reg);
            out_req.last       = (rd_addr_reg == LAST_ADDR);
        end

        case (state_reg)
            ST_IDLE: begin
                // empty buffer drops everything but the sync byte
                if (s_acc && (fill_reg != '0 || s_rx_byte == SYNC_BYTE)) begin
                    mem_wr_en = 1'b1;
                    fill_next = fill_reg + FW'(1);
                    if (fill_reg == FW'(1)) begin
                        byte1_next = s_rx_byte;
                    end
                    if (fill_reg == FW'(FRAME_BYTES - 1)) begin
                        state_next    = ST_SUM;
                        cnt_next      = AW'(2);
                        iss_done_next = 1'b0;
                        acc_next      = '0;
                    end
                end
            end
            ST_SUM: begin
                if (!iss_done_reg) begin
                    mem_rd_en = 1'b1;
                    cnt_next  = cnt_reg + AW'(1);
                    if (cnt_reg == LAST_ADDR) begin
                        iss_done_next = 1'b1;
                    end
                end
                if (rd_vld_reg) begin
                    acc_next = sum_now;
                    if (rd_last_reg) begin
                        if (sum_now == byte1_reg) begin
                            state_next = ST_EMIT;
                            cnt_next   = '0;
                        end else begin
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_EMIT: begin
                // one read in flight at a time, only when the result slot frees up
                if (!emit_pend_reg && out_free) begin
                    mem_rd_en      = 1'b1;
                    emit_pend_next = 1'b1;
                    cnt_next       = cnt_reg + AW'(1);
                    if (cnt_reg == LAST_ADDR) begin
                        state_next = ST_IDLE;
                        fill_next  = '0;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_req.load       = 1'b1;
                    out_req.data_byte  = '0;
                    out_req.byte_index = '0;
                    out_req.last       = 1'b1;
                    out_req.frame_bad  = 1'b1;
                    state_next         = ST_SCAN;
                    cnt_next           = AW'(1);
                    iss_done_next      = 1'b0;
                    found_next         = 1'b0;
                end
            end
            ST_SCAN: begin
                // read from entry 1 upward; after the first sync byte copy each entry down
                if (!iss_done_reg) begin
                    mem_rd_en = 1'b1;
                    cnt_next  = cnt_reg + AW'(1);
                    if (cnt_reg == LAST_ADDR) begin
                        iss_done_next = 1'b1;
                    end
                end
                if (rd_vld_reg) begin
                    if (found_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = copy_dst;
                        mem_wr_data = mem_rd_data;
                        if (copy_dst == AW'(1)) begin
                            byte1_next = mem_rd_data;
                        end
                    end else if (mem_rd_data == SYNC_BYTE) begin
                        found_next  = 1'b1;
                        off_next    = rd_addr_reg;
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = mem_rd_data;
                    end
                    if (rd_last_reg) begin
                        state_next = ST_IDLE;
                        if (found_next) begin
                            fill_next = FW'(FRAME_BYTES) - FW'(off_next);
                        end else begin
                            fill_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        rd_vld_next  = mem_rd_en && !emit_pend_next;
        rd_addr_next = mem_rd_en ? cnt_reg : rd_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            iss_done_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            emit_pend_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            iss_done_reg  <= iss_done_next;
            rd_vld_reg    <= rd_vld_next;
            emit_pend_reg <= emit_pend_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        rd_last_reg <= rd_last_next;
        rd_addr_reg <= rd_addr_next;
        acc_reg     <= acc_next;
        byte1_reg   <= byte1_next;
        off_reg     <= off_next;
    end

    scr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (cnt_reg),
        .rd_data (mem_rd_data)
    );

    scr_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (out_req),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .m_frame_bad  (m_frame_bad),
        .free         (out_free)
    );

`ifndef SYNTHESIS
    // checksum walk and frame emission never touch the buffer contents
    a_no_write_while_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM || state_reg == ST_EMIT) |-> !mem_wr_en)
        else $error("frame ram written during checksum or emission");

    // an emit read only lands in an empty result register
    a_emit_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_pend_reg |-> !m_valid)
        else $error("emit read landed on an occupied result register");

    // sum/scan read data only arrives while its walk is still running
    a_read_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SUM || state_reg == ST_SCAN))
        else $error("walk read data outside its walk");

    // while collecting, the buffer never holds a full frame
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (fill_reg <= FW'(FRAME_BYTES - 1)))
        else $error("fill count reached a full frame while idle");

    // an error word is always followed by the resync walk
    a_err_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ERR && out_free) |=> (state_reg == ST_SCAN))
        else $error("error word not followed by resync");
`endif

endmodule

### tb/scr_frame_checker.sv
// result checker for the sync-framed checksum receiver: keeps its own image of the
// frame buffer, works out every result word and compares it with what the block sends
// depends on scr_pkg
`timescale 1ns / 1ps

module scr_frame_checker #(
    parameter int FRAME_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data_byte,
    input  logic [5:0] m_byte_index,
    input  logic       m_last,
    input  logic       m_frame_bad,
    output int         fail_count,
    output int         words_pending,
    output int         words_checked,
    output int         stored_bytes,
    output int         good_frames,
    output int         bad_frames
);

    import scr_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       frame_bad;
    } frame_word_t;

    logic [7:0]  frame_image [FRAME_BYTES];
    int          fill_level;
    frame_word_t expected_words [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s is %0h, expected %0h (result word %0d)",
                 $realtime, what, got, want, words_checked);
        fail_count++;
    endtask

    // one received byte through the frame assembler
    task automatic absorb_rx_byte(input logic [7:0] rx);
        logic [7:0]  csum;
        int          sync_at;
        frame_word_t w;
        if (fill_level == 0 && rx != SYNC_BYTE)
            return;
        frame_image[fill_level] = rx;
        fill_level++;
        stored_bytes++;
        if (fill_level < FRAME_BYTES)
            return;

        csum = 8'h00;
        for (int i = 2; i < FRAME_BYTES; i++)
            csum += frame_image[i];

        if (csum == frame_image[1]) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                w.data_byte  = frame_image[i];
                w.byte_index = 6'(i);
                w.last       = (i == FRAME_BYTES - 1);
                w.frame_bad  = 1'b0;
                expected_words.push_back(w);
            end
            fill_level = 0;
            good_frames++;
        end else begin
            w = '{data_byte: 8'h00, byte_index: 6'd0, last: 1'b1, frame_bad: 1'b1};
            expected_words.push_back(w);
            bad_frames++;
            // resynchronise on the first sync value past the head
            sync_at = 0;
            for (int p = 1; p < FRAME_BYTES && sync_at == 0; p++)
                if (frame_image[p] == SYNC_BYTE)
                    sync_at = p;
            if (sync_at != 0) begin
                for (int i = 0; i < FRAME_BYTES - sync_at; i++)
                    frame_image[i] = frame_image[i + sync_at];
                fill_level = FRAME_BYTES - sync_at;
            end else begin
                fill_level = 0;
            end
        end
    endtask

    task automatic check_result_word();
        frame_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, data_byte", m_data_byte, 0);
            return;
        end
        want = expected_words.pop_front();
        if (m_data_byte !== want.data_byte)
            report_mismatch("data_byte", m_data_byte, want.data_byte);
        if (m_byte_index !== want.byte_index)
            report_mismatch("byte_index", m_byte_index, want.byte_index);
        if (m_last !== want.last)
            report_mismatch("last", m_last, want.last);
        if (m_frame_bad !== want.frame_bad)
            report_mismatch("frame_bad", m_frame_bad, want.frame_bad);
        words_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_level    = 0;
            expected_words.delete();
            stored_bytes  = 0;
            good_frames   = 0;
            bad_frames    = 0;
            words_checked = 0;
        end else begin
            if (m_valid && m_ready)
                check_result_word();
            if (s_valid && s_ready)
                absorb_rx_byte(s_rx_byte);
        end
        words_pending = expected_words.size();
    end

endmodule

### tb/sync_checksum_frame_receiver_core_tb.sv
// top of the testbench for the sync-framed checksum receiver: clock, reset, byte
// stimulus, sink pacing and the verdict; checking is left to scr_frame_checker
// depends on scr_pkg, scr_frame_checker and the receiver rtl
`timescale 1ns / 1ps

module sync_checksum_frame_receiver_core_tb;

    import scr_pkg::*;

    localparam int FRAME_BYTES       = 64;
    localparam int CYCLE_LIMIT       = 600000;
    // a checksum or resync walk plus a full frame stream, with margin
    localparam int SETTLE_CYCLES     = 4 * FRAME_BYTES;
    localparam int HOLD_OFF_CYCLES   = 600;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data_byte;
    logic [5:0] m_byte_index;
    logic       m_last;
    logic       m_frame_bad;

    int fail_count;
    int words_pending;
    int words_checked;
    int stored_bytes;
    int good_frames;
    int bad_frames;
    int cycle_count = 0;

    // frame being put together for transmission
    logic [7:0] tx_frame [FRAME_BYTES];
    // sender side: no gaps at all while set
    logic       burst_mode   = 1'b0;
    // asks the sink process for its long hold-off
    logic       hold_off_req = 1'b0;

    always #6 aclk = ~aclk;

    sync_checksum_frame_receiver_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .m_frame_bad  (m_frame_bad)
    );

    scr_frame_checker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) frame_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_index  (m_byte_index),
        .m_last        (m_last),
        .m_frame_bad   (m_frame_bad),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .stored_bytes  (stored_bytes),
        .good_frames   (good_frames),
        .bad_frames    (bad_frames)
    );

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one word at a falling edge and hold it until the block takes it
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        gap = burst_mode ? 0 : sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame_from(input int first);
        for (int i = first; i < FRAME_BYTES; i++)
            send_byte(tx_frame[i]);
    endtask

    // byte 1 carries the 8-bit sum of bytes 2 and up
    task automatic seal_frame();
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 2; i < FRAME_BYTES; i++)
            acc += tx_frame[i];
        tx_frame[1] = acc;
    endtask

    // sync head plus random payload, sync values inside at the given percentage
    task automatic fill_random_payload(input int sync_pct);
        tx_frame[0] = SYNC_BYTE;
        for (int i = 2; i < FRAME_BYTES; i++)
            tx_frame[i] = ($urandom_range(0, 99) < sync_pct) ? SYNC_BYTE
                                                             : 8'($urandom_range(0, 254));
    endtask

    // sender pause: nothing offered until every expected word is back and the block is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // run limit, counted in clock cycles
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d words still expected",
                     cycle_count, words_pending);
            $display("[sync_checksum_frame_receiver_core] ERROR");
            $finish;
        end
    end

    // sink pacing: random ready pattern, long ready stretches now and then, and one
    // long hold-off right after reset so the block backs up
    initial begin : sink_pacing
        int  run;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 12);
            repeat (run) @(negedge aclk);
            m_ready <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                              : $urandom_range(1, 3);
            repeat (run) @(negedge aclk);
        end
    end

    initial begin : byte_stimulus
        logic [7:0] fix_byte;

        // the sink holds off from the start; the first frame goes in without gaps,
        // so the block fills and stalls while the next frame is offered
        hold_off_req = 1'b1;
        burst_mode   = 1'b1;

        // synchronous reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // noise while the buffer is empty is dropped: extremes and the values next to sync
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFE);

        // good frame whose payload holds zero and sync values, one of them last
        tx_frame[0] = SYNC_BYTE;
        for (int i = 2; i < FRAME_BYTES; i++)
            tx_frame[i] = 8'(i * 37);
        tx_frame[2]               = 8'h00;
        tx_frame[3]               = SYNC_BYTE;
        tx_frame[FRAME_BYTES - 1] = SYNC_BYTE;
        seal_frame();
        send_frame_from(0);
        burst_mode = 1'b0;

        // bad checksum with no sync value past the head: buffer emptied,
        // so the following noise word is dropped again
        tx_frame[0] = SYNC_BYTE;
        for (int i = 2; i < FRAME_BYTES; i++)
            tx_frame[i] = 8'(i);
        seal_frame();
        tx_frame[1] ^= 8'h5A;
        send_frame_from(0);
        send_byte(8'h3C);

        drain_results();

        // bad checksum whose only later sync value is the last byte: that byte
        // becomes the head of the next frame, completed by 63 more bytes
        tx_frame[0] = SYNC_BYTE;
        for (int i = 2; i < FRAME_BYTES; i++)
            tx_frame[i] = 8'(i + 100);
        tx_frame[FRAME_BYTES - 1] = SYNC_BYTE;
        seal_frame();
        tx_frame[1] ^= 8'h01;
        send_frame_from(0);
        fill_random_payload(0);
        seal_frame();
        send_frame_from(1);

        // checksum byte is itself the sync value and wrong: resync at position one
        // keeps 63 bytes, and one chosen byte then completes a good frame
        tx_frame[0] = SYNC_BYTE;
        tx_frame[1] = SYNC_BYTE;
        for (int i = 2; i < FRAME_BYTES; i++)
            tx_frame[i] = 8'(i);
        send_frame_from(0);
        fix_byte = tx_frame[2];
        for (int i = 3; i < FRAME_BYTES; i++)
            fix_byte -= tx_frame[i];
        send_byte(fix_byte);

        drain_results();

        $display("%0d bytes stored, %0d good frames streamed, %0d checksum failures with resync",
                 stored_bytes, good_frames, bad_frames);
        $display("%0d result words compared, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0 && words_pending == 0)
            $display("[sync_checksum_frame_receiver_core] OK");
        else
            $display("[sync_checksum_frame_receiver_core] ERROR");
        $finish;
    end

endmodule
